>>> hdl/ffp_pkg.sv
`timescale 1ns / 1ps

package ffp_pkg;

   localparam int FrameLen   = 9;
   localparam int BccLen     = 7;
   localparam int FillW      = 4;
   localparam int QueueDepth = 2;

   localparam logic [7:0] FRAME_HEADER = 8'h7A;
   localparam logic [7:0] FRAME_TAIL   = 8'h7B;
   localparam logic [7:0] TYPE_COUNT   = 8'd5;

   localparam logic [7:0] X_ADDR_RESET  = 8'd1;
   localparam logic [7:0] Y_ADDR_RESET  = 8'd2;
   localparam logic [7:0] TIMEOUT_RESET = 8'd20;
   localparam logic [7:0] IDLE_MAX      = 8'hFF;

   typedef enum logic {
      ACT_BYTE = 1'b0,
      ACT_TICK = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      CSR_X_ADDR  = 2'd0,
      CSR_Y_ADDR  = 2'd1,
      CSR_TIMEOUT = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FRAME_ERR = 2'd1,
      ST_BCC_ERR   = 2'd2,
      ST_TIMEOUT   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] x_addr;
      logic [7:0] y_addr;
      logic [7:0] timeout;
   } cfg_type;

   typedef struct packed {
      action_type action;
      logic [7:0] rx_byte;
   } word_type;

   typedef struct packed {
      logic     valid;
      word_type word;
   } queue_head_type;

   typedef struct packed {
      status_type  status;
      logic        axis_known;
      logic        axis;
      logic [2:0]  fb_kind;
      logic [31:0] feedback_value;
   } result_type;

endpackage

>>> hdl/ffp_if.sv
`timescale 1ns / 1ps

interface ffp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

interface ffp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        axis_known;
   logic        axis;
   logic [2:0]  fb_kind;
   logic [31:0] feedback_value;

   modport source (output valid, output status, output axis_known, output axis,
                   output fb_kind, output feedback_value, input ready);
   modport sink   (input valid, input status, input axis_known, input axis,
                   input fb_kind, input feedback_value, output ready);
endinterface

interface ffp_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/ffp_front.sv
`timescale 1ns / 1ps

module ffp_front (
   input  logic                    clock,
   input  logic                    reset,
   ffp_req_if.sink                 req,
   output ffp_pkg::queue_head_type head,
   input  logic                    pop
);

   ffp_pkg::word_type entries_ff [ffp_pkg::QueueDepth];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              do_pop;
   ffp_pkg::word_type word;

   always_comb begin
      word.action  = ffp_pkg::action_type'(req.action);
      word.rx_byte = req.rx_byte;
   end

   assign req.ready = (count_ff != 2'(ffp_pkg::QueueDepth));
   assign push      = req.valid && req.ready;
   assign do_pop    = pop && (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.word  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= word;
      end
   end

endmodule

>>> hdl/ffp_back.sv
`timescale 1ns / 1ps

module ffp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  ffp_pkg::cfg_type        cfg,
   input  ffp_pkg::queue_head_type head,
   output logic                    pop,
   ffp_rsp_if.source               rsp
);

   logic [7:0]               store_ff [ffp_pkg::FrameLen];
   logic [7:0]               store_in [ffp_pkg::FrameLen];
   logic [7:0]               full     [ffp_pkg::FrameLen];
   logic [ffp_pkg::FillW-1:0] fill_ff, fill_in;
   logic [7:0]               idle_ff, idle_in;
   logic                     out_valid_ff, out_valid_in;
   ffp_pkg::result_type      out_ff, out_in;
   logic                     can_adv;
   logic [7:0]               byte_in;
   logic [7:0]               bcc;
   logic                     is_x;
   logic                     known;
   logic                     frame_bad;
   logic [ffp_pkg::FillW-1:0] hdr_pos;
   logic                     hdr_found;
   logic [ffp_pkg::FillW:0]  src;

   assign can_adv = !out_valid_ff || rsp.ready;
   assign pop     = head.valid && can_adv;
   assign byte_in = head.word.rx_byte;

   // frame as it stands once the incoming word lands in the last slot
   always_comb begin
      for (int i = 0; i < ffp_pkg::FrameLen - 1; i++) begin
         full[i] = store_ff[i];
      end
      full[ffp_pkg::FrameLen-1] = byte_in;
   end

   always_comb begin
      bcc = 8'd0;
      for (int i = 0; i < ffp_pkg::BccLen; i++) begin
         bcc = bcc ^ full[i];
      end
   end

   assign is_x      = (full[1] == cfg.x_addr);
   assign known     = is_x || (full[1] == cfg.y_addr);
   assign frame_bad = (full[0] != ffp_pkg::FRAME_HEADER)
                   || (full[ffp_pkg::FrameLen-1] != ffp_pkg::FRAME_TAIL)
                   || !known || (full[2] >= ffp_pkg::TYPE_COUNT);

   // first header byte past position zero
   always_comb begin
      hdr_pos   = '0;
      hdr_found = 1'b0;
      for (int i = ffp_pkg::FrameLen - 1; i >= 1; i--) begin
         if (full[i] == ffp_pkg::FRAME_HEADER) begin
            hdr_pos   = ffp_pkg::FillW'(i);
            hdr_found = 1'b1;
         end
      end
   end

   always_comb begin
      fill_in      = fill_ff;
      idle_in      = idle_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      src          = '0;
      for (int i = 0; i < ffp_pkg::FrameLen; i++) begin
         store_in[i] = store_ff[i];
      end

      if (pop) begin
         out_valid_in = 1'b0;
         if (head.word.action == ffp_pkg::ACT_TICK) begin
            if (idle_ff != ffp_pkg::IDLE_MAX) begin
               idle_in = idle_ff + 8'd1;
            end
            if ((fill_ff != '0) && (idle_in >= cfg.timeout)) begin
               fill_in      = '0;
               out_valid_in = 1'b1;
               out_in       = '{status: ffp_pkg::ST_TIMEOUT, axis_known: 1'b0,
                                axis: 1'b0, fb_kind: 3'd0,
                                feedback_value: 32'd0};
            end
         end else begin
            idle_in = 8'd0;
            if (fill_ff == '0) begin
               if (byte_in == ffp_pkg::FRAME_HEADER) begin
                  store_in[0] = byte_in;
                  fill_in     = ffp_pkg::FillW'(1);
               end
            end else if (fill_ff >= ffp_pkg::FillW'(ffp_pkg::FrameLen)) begin
               fill_in = '0;
            end else if (fill_ff != ffp_pkg::FillW'(ffp_pkg::FrameLen - 1)) begin
               store_in[fill_ff] = byte_in;
               fill_in           = fill_ff + ffp_pkg::FillW'(1);
            end else begin
               out_valid_in             = 1'b1;
               out_in.axis_known        = known;
               out_in.axis              = !is_x && known;
               out_in.fb_kind           = full[2][2:0];
               out_in.feedback_value    = {full[3], full[4], full[5], full[6]};
               if (frame_bad) begin
                  out_in.status = ffp_pkg::ST_FRAME_ERR;
               end else if (bcc != full[ffp_pkg::BccLen]) begin
                  out_in.status = ffp_pkg::ST_BCC_ERR;
               end else begin
                  out_in.status = ffp_pkg::ST_OK;
               end
               if (out_in.status == ffp_pkg::ST_OK || !hdr_found) begin
                  fill_in = '0;
               end else begin
                  // shift the tail from the next header down to the front
                  fill_in = ffp_pkg::FillW'(ffp_pkg::FrameLen) - hdr_pos;
                  for (int i = 0; i < ffp_pkg::FrameLen; i++) begin
                     src = (ffp_pkg::FillW + 1)'(i) + {1'b0, hdr_pos};
                     if (src < (ffp_pkg::FillW + 1)'(ffp_pkg::FrameLen)) begin
                        store_in[i] = full[src[ffp_pkg::FillW-1:0]];
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         idle_ff      <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         idle_ff      <= idle_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      for (int i = 0; i < ffp_pkg::FrameLen; i++) begin
         store_ff[i] <= store_in[i];
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.status         = out_ff.status;
   assign rsp.axis_known     = out_ff.axis_known;
   assign rsp.axis           = out_ff.axis;
   assign rsp.fb_kind        = out_ff.fb_kind;
   assign rsp.feedback_value = out_ff.feedback_value;

endmodule

>>> hdl/feedback_frame_parser.sv
`timescale 1ns / 1ps

// channel    dir  word
// req_chan   in   action, rx_byte (received byte or millisecond tick)
// rsp_chan   out  status, axis_known, axis, fb_kind, feedback_value
// csr_chan   in   index, data (register write, always ready)
//
// One word per cycle sustained while rsp_chan is ready; a result is registered:
// the word is written into the two-word input queue, waits at its head and
// passes the frame check into the output register when it is popped.
// Reset clears the queue, fill count, idle counter and output valid, and loads
// the register reset values.
// A stalled rsp_chan holds the output register, then the queue fills and
// req_chan.ready drops.

module feedback_frame_parser (
   input  logic      clock,
   input  logic      reset,
   ffp_req_if.sink   req_chan,
   ffp_rsp_if.source rsp_chan,
   ffp_csr_if.sink   csr_chan
);

   ffp_pkg::cfg_type        cfg_ff, cfg_in;
   ffp_pkg::queue_head_type head;
   logic                    pop;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            ffp_pkg::CSR_X_ADDR:  cfg_in.x_addr  = csr_chan.data;
            ffp_pkg::CSR_Y_ADDR:  cfg_in.y_addr  = csr_chan.data;
            ffp_pkg::CSR_TIMEOUT: cfg_in.timeout = csr_chan.data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{x_addr: ffp_pkg::X_ADDR_RESET, y_addr: ffp_pkg::Y_ADDR_RESET,
                     timeout: ffp_pkg::TIMEOUT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ffp_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .head  (head),
      .pop   (pop)
   );

   ffp_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

`ifndef SYNTH
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == ffp_pkg::ST_TIMEOUT) |->
         (!rsp_chan.axis_known && !rsp_chan.axis &&
          rsp_chan.fb_kind == 3'd0 && rsp_chan.feedback_value == 32'd0))
      else $error("timeout result carries frame fields");

   a_axis_known: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.axis) |-> rsp_chan.axis_known)
      else $error("Y axis reported for unknown address");

   a_good_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == ffp_pkg::ST_OK) |->
         (rsp_chan.axis_known && rsp_chan.fb_kind < 3'd5))
      else $error("good frame with bad address or type");

   a_pop_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");
`endif

endmodule
